[rtl/core/cba_pkg.sv]
// Shared types and constants for the contiguous block allocator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package cba_pkg;

  localparam int DEF_MAX_BLOCKS = 64;
  localparam logic [15:0] DEF_MEMORY_SIZE = 16'hFFFF;

  // Request kinds.
  localparam logic [2:0] KIND_FIRST   = 3'd0;
  localparam logic [2:0] KIND_BEST    = 3'd1;
  localparam logic [2:0] KIND_WORST   = 3'd2;
  localparam logic [2:0] KIND_FREE    = 3'd3;
  localparam logic [2:0] KIND_COMPACT = 3'd4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOMEM    = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOHOLE   = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_START,
    CMD_SCAN_RD,
    CMD_SCAN_EV,
    CMD_TAIL,
    CMD_INS_INIT,
    CMD_INS_RD,
    CMD_INS_WR,
    CMD_PUT,
    CMD_DEL_INIT,
    CMD_DEL_RD,
    CMD_DEL_WR,
    CMD_DEL_FIN,
    CMD_CMP_RD,
    CMD_CMP_WR,
    CMD_RESULT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       nomem;
    logic       idx_lt_count;
    logic       idx_gt_pos;
    logic       id_found;
    logic       full;
    logic       hole_found;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_TAIL,
    S_CHOOSE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_CMP_RD,
    S_CMP_WR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] base;
    logic [15:0] limit;
  } entry_t;

endpackage

`default_nettype wire

[rtl/core/cba_ctrl.sv]
// Sequencer of the contiguous block allocator.
// Uses cba_pkg; drives the datapath cba_dp through command and status structs.
`default_nettype none

module cba_ctrl
  import cba_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t  state_r, state_nxt;
  status_t res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= ST_OK;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    res_nxt    = res_r;
    cmd.op     = CMD_NONE;
    cmd.status = res_r;
    busy       = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = CMD_START;
          res_nxt   = ST_OK;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.kind <= KIND_WORST) begin
          if (stat.nomem) begin
            res_nxt   = ST_NOMEM;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end else if (stat.kind == KIND_FREE) begin
          state_nxt = S_SCAN_RD;
        end else if (stat.kind == KIND_COMPACT) begin
          state_nxt = S_CMP_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_SCAN_RD: begin
        if (stat.idx_lt_count) begin
          cmd.op    = CMD_SCAN_RD;
          state_nxt = S_SCAN_EV;
        end else if (stat.kind == KIND_FREE) begin
          if (stat.id_found) begin
            cmd.op    = CMD_DEL_INIT;
            state_nxt = S_DEL_RD;
          end else begin
            res_nxt   = ST_NOTFOUND;
            state_nxt = S_RESP;
          end
        end else begin
          state_nxt = S_TAIL;
        end
      end
      S_SCAN_EV: begin
        cmd.op    = CMD_SCAN_EV;
        state_nxt = S_SCAN_RD;
      end
      S_TAIL: begin
        cmd.op    = CMD_TAIL;
        state_nxt = S_CHOOSE;
      end
      S_CHOOSE: begin
        if (stat.id_found) begin
          res_nxt   = ST_DUP;
          state_nxt = S_RESP;
        end else if (stat.full) begin
          res_nxt   = ST_FULL;
          state_nxt = S_RESP;
        end else if (!stat.hole_found) begin
          res_nxt   = ST_NOHOLE;
          state_nxt = S_RESP;
        end else begin
          cmd.op    = CMD_INS_INIT;
          state_nxt = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (stat.idx_gt_pos) begin
          cmd.op    = CMD_INS_RD;
          state_nxt = S_INS_WR;
        end else begin
          cmd.op    = CMD_PUT;
          state_nxt = S_RESP;
        end
      end
      S_INS_WR: begin
        cmd.op    = CMD_INS_WR;
        state_nxt = S_INS_RD;
      end
      S_DEL_RD: begin
        if (stat.idx_lt_count) begin
          cmd.op    = CMD_DEL_RD;
          state_nxt = S_DEL_WR;
        end else begin
          cmd.op    = CMD_DEL_FIN;
          state_nxt = S_RESP;
        end
      end
      S_DEL_WR: begin
        cmd.op    = CMD_DEL_WR;
        state_nxt = S_DEL_RD;
      end
      S_CMP_RD: begin
        if (stat.idx_lt_count) begin
          cmd.op    = CMD_CMP_RD;
          state_nxt = S_CMP_WR;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_CMP_WR: begin
        cmd.op    = CMD_CMP_WR;
        state_nxt = S_CMP_RD;
      end
      S_RESP: begin
        cmd.op    = CMD_RESULT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/cba_dp.sv]
// Datapath of the contiguous block allocator: block table memory, counters,
// hole tracking and result registers. Uses cba_pkg; driven by cba_ctrl.
`default_nettype none

module cba_dp
  import cba_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic [2:0]  in_kind,
  input  wire logic [15:0] in_block_id,
  input  wire logic [15:0] in_block_size,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [15:0]      out_block_start,
  output logic [15:0]      out_free_left
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  entry_t mem [MAX_BLOCKS];
  entry_t rdata_r;

  logic [15:0]   memory_size_r, remaining_r;
  logic [CW-1:0] count_r, idx_r, pos_r, fidx_r;
  logic [2:0]    kind_r;
  logic [15:0]   id_r, size_r, prev_end_r, top_r, pick_r, at_r, fsz_r;
  logic          id_found_r, hole_found_r;
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [15:0]   out_block_start_r, out_free_left_r;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  entry_t        wdata;
  logic [CW-1:0] idx_m1;
  logic [15:0]   hole_hi, esz;
  logic [16:0]   hole_sz, free_sum;
  logic          fits, better, take;

  assign idx_m1 = idx_r - CW'(1);

  // Hole between the previous block end and the next block start (or the top).
  assign hole_hi = (cmd.op == CMD_TAIL) ? memory_size_r : rdata_r.base;
  assign hole_sz = {1'b0, hole_hi} - {1'b0, prev_end_r};
  assign fits    = !hole_sz[16] && (hole_sz[15:0] >= size_r);
  assign better  = ((kind_r == KIND_BEST) && (hole_sz[15:0] < pick_r)) ||
                   ((kind_r == KIND_WORST) && (hole_sz[15:0] > pick_r));
  assign take    = fits && (!hole_found_r || better);
  assign esz     = (rdata_r.limit >= rdata_r.base) ? (rdata_r.limit - rdata_r.base) : 16'd0;
  assign free_sum = {1'b0, remaining_r} + {1'b0, fsz_r};

  always_comb begin
    we    = 1'b0;
    waddr = idx_r[IW-1:0];
    raddr = idx_r[IW-1:0];
    wdata = rdata_r;
    case (cmd.op)
      CMD_INS_RD: raddr = idx_m1[IW-1:0];
      CMD_INS_WR: we = 1'b1;
      CMD_PUT: begin
        we    = 1'b1;
        waddr = pos_r[IW-1:0];
        wdata = '{id: id_r, base: at_r, limit: at_r + size_r};
      end
      CMD_DEL_WR: begin
        we    = 1'b1;
        waddr = idx_m1[IW-1:0];
      end
      CMD_CMP_WR: begin
        we    = 1'b1;
        wdata = '{id: rdata_r.id, base: top_r, limit: top_r + esz};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      memory_size_r <= DEF_MEMORY_SIZE;
      remaining_r   <= DEF_MEMORY_SIZE;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == CMD_RESULT);
      if (cfg_we) begin
        memory_size_r <= cfg_wdata;
        remaining_r   <= cfg_wdata;
        count_r       <= '0;
      end
      case (cmd.op)
        CMD_PUT: begin
          count_r     <= count_r + CW'(1);
          remaining_r <= remaining_r - size_r;
        end
        CMD_DEL_FIN: begin
          count_r     <= count_r - CW'(1);
          remaining_r <= free_sum[16] ? 16'hFFFF : free_sum[15:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_START: begin
        kind_r       <= in_kind;
        id_r         <= in_block_id;
        size_r       <= in_block_size;
        idx_r        <= '0;
        prev_end_r   <= '0;
        top_r        <= '0;
        at_r         <= '0;
        id_found_r   <= 1'b0;
        hole_found_r <= 1'b0;
      end
      CMD_SCAN_EV: begin
        if (!id_found_r && (rdata_r.id == id_r)) begin
          id_found_r <= 1'b1;
          fidx_r     <= idx_r;
          fsz_r      <= esz;
        end
        if (take) begin
          hole_found_r <= 1'b1;
          pick_r       <= hole_sz[15:0];
          pos_r        <= idx_r;
          at_r         <= prev_end_r;
        end
        prev_end_r <= rdata_r.limit;
        idx_r      <= idx_r + CW'(1);
      end
      CMD_TAIL: begin
        if (take) begin
          hole_found_r <= 1'b1;
          pick_r       <= hole_sz[15:0];
          pos_r        <= idx_r;
          at_r         <= prev_end_r;
        end
      end
      CMD_INS_INIT: idx_r <= count_r;
      CMD_INS_WR:   idx_r <= idx_m1;
      CMD_DEL_INIT: idx_r <= fidx_r + CW'(1);
      CMD_DEL_WR:   idx_r <= idx_r + CW'(1);
      CMD_CMP_WR: begin
        top_r <= top_r + esz;
        idx_r <= idx_r + CW'(1);
      end
      CMD_RESULT: begin
        out_status_r      <= cmd.status;
        out_block_start_r <= ((cmd.status == ST_OK) && (kind_r <= KIND_WORST)) ? at_r : 16'd0;
        out_free_left_r   <= remaining_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.kind         = kind_r;
    stat.nomem        = size_r > remaining_r;
    stat.idx_lt_count = idx_r < count_r;
    stat.idx_gt_pos   = idx_r > pos_r;
    stat.id_found     = id_found_r;
    stat.full         = count_r >= CW'(MAX_BLOCKS);
    stat.hole_found   = hole_found_r;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_start = out_block_start_r;
  assign out_free_left   = out_free_left_r;

endmodule

`default_nettype wire

[rtl/core/contiguous_block_allocator.sv]
// Top level of the contiguous block allocator.
// Uses cba_pkg; instantiates the sequencer cba_ctrl and the datapath cba_dp.
`default_nettype none

// Usage:
// A request beat is taken on a rising edge where start is high and busy is
// low; in_kind selects first-fit, best-fit or worst-fit allocation, free by
// id, or compaction. Exactly one result beat follows each request: out_valid
// is high for one cycle with out_status, out_block_start and out_free_left.
// The receiver cannot stall; a result must be captured in its cycle.
// An allocation scans the table entry by entry, evaluates the top hole, then
// moves the entries above the chosen hole up one at a time. A free scans the
// table, then moves the entries above the freed one down; a compaction moves
// each block down to close the holes; a request short of memory is rejected
// without a scan. The block table has one write port and one registered
// read port. busy stays high until the result beat's cycle, so the next
// request can be taken while it is shown. Reset empties the table and sets
// the memory size and free units to 65535. A write on cfg_we sets the
// memory size, empties the table and resets the free units; the user must
// do so only while the block is idle, as the block does not enforce it.

module contiguous_block_allocator
  import cba_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_kind,
  input  wire logic [15:0] in_block_id,
  input  wire logic [15:0] in_block_size,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [15:0]      out_block_start,
  output logic [15:0]      out_free_left
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The sequencer walks the table one entry at a time through the datapath.
  cba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // The datapath holds the table, the counts and the result registers.
  cba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_kind         (in_kind),
    .in_block_id     (in_block_id),
    .in_block_size   (in_block_size),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_block_start (out_block_start),
    .out_free_left   (out_free_left)
  );

  // A result beat always closes a busy period.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a preceding busy cycle");

  // An accepted request makes the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // Rejected requests never report a start address.
  a_start_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_block_start == 16'd0))
    else $error("nonzero start address on a rejected request");

  // The table never exceeds its capacity.
  a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == CMD_PUT) |-> !stat.full)
    else $error("insertion into a full table");

endmodule

`default_nettype wire
